// ===== rtl/core/sah_pkg.sv =====
package sah_pkg;

  localparam int MAX_GRID     = 256;
  localparam int MAX_STEPS    = 512;
  localparam int COUNT_WIDTH  = 32;
  localparam int BIN_DEPTH    = MAX_GRID * MAX_GRID;
  localparam int BIN_AW       = $clog2(BIN_DEPTH);
  localparam int COORD_W      = $clog2(MAX_GRID);
  localparam int CORDIC_STEPS = 24;
  localparam int ANG_W        = 28;
  localparam int ROT_W        = 34;
  localparam int Q_DEPTH      = 4;
  localparam int Q_AW         = $clog2(Q_DEPTH);

  localparam logic signed [ANG_W-1:0] Q24_PI      = 28'sd52707179;
  localparam logic signed [ANG_W-1:0] Q24_TWO_PI  = 28'sd105414358;
  localparam logic signed [ANG_W-1:0] Q24_HALF_PI = 28'sd26353589;
  localparam logic signed [ROT_W-1:0] Q30_INV_GAIN = 34'sd652032874;

  localparam logic [1:0] OP_ACC   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_RDCLR = 2'd2;

  localparam logic [1:0] REG_GRID  = 2'd0;
  localparam logic [1:0] REG_STEPS = 2'd1;
  localparam logic [1:0] REG_ANGLE = 2'd2;
  localparam logic [1:0] REG_SCALE = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [ANG_W-1:0] tilt;
    logic signed [ANG_W-1:0] dir;
    logic [BIN_AW-1:0]       bin_index;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_rd_t;

  typedef struct packed {
    logic clearing;
  } bk_stat_t;

  typedef struct packed {
    logic [8:0]  grid_size;
    logic [9:0]  step_count;
    logic [24:0] angle_step;
    logic [31:0] bin_scale;
  } cfg_t;

  function automatic logic signed [ANG_W-1:0] atan_q24(input logic [4:0] i);
    logic signed [ANG_W-1:0] r;
    case (i)
      5'd0:  r = 28'sd13176795;
      5'd1:  r = 28'sd7778716;
      5'd2:  r = 28'sd4110060;
      5'd3:  r = 28'sd2086331;
      5'd4:  r = 28'sd1047214;
      5'd5:  r = 28'sd524117;
      5'd6:  r = 28'sd262123;
      5'd7:  r = 28'sd131069;
      5'd8:  r = 28'sd65536;
      5'd9:  r = 28'sd32768;
      5'd10: r = 28'sd16384;
      5'd11: r = 28'sd8192;
      5'd12: r = 28'sd4096;
      5'd13: r = 28'sd2048;
      5'd14: r = 28'sd1024;
      5'd15: r = 28'sd512;
      5'd16: r = 28'sd256;
      5'd17: r = 28'sd128;
      5'd18: r = 28'sd64;
      5'd19: r = 28'sd32;
      5'd20: r = 28'sd16;
      5'd21: r = 28'sd8;
      5'd22: r = 28'sd4;
      5'd23: r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

  // operand lies in (-2pi, 2pi)
  function automatic logic signed [ANG_W-1:0] wrap_q24(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] r;
    r = a;
    if (r >= Q24_PI) r = r - Q24_TWO_PI;
    if (r < -Q24_PI) r = r + Q24_TWO_PI;
    return r;
  endfunction

endpackage

// ===== rtl/core/sah_in_if.sv =====
interface sah_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] x_slope;
  logic signed [31:0] y_slope;
  logic [15:0]        bin_index;

  modport source (output valid, operation, x_slope, y_slope, bin_index, input ready);
  modport sink (input valid, operation, x_slope, y_slope, bin_index, output ready);
endinterface

// ===== rtl/core/sah_out_if.sv =====
interface sah_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] bin_count;

  modport source (output valid, bin_count, input ready);
  modport sink (input valid, bin_count, output ready);
endinterface

// ===== rtl/core/sah_front.sv =====
module sah_front (
  input  logic              clk,
  input  logic              rst_n,
  sah_in_if.sink            in_ch,
  input  logic              q_full,
  input  sah_pkg::bk_stat_t bk_stat,
  output sah_pkg::q_wr_t    q_wr
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_SQX  = 3'd1;
  localparam logic [2:0] F_SQY  = 3'd2;
  localparam logic [2:0] F_SQRT = 3'd3;
  localparam logic [2:0] F_VEC  = 3'd4;
  localparam logic [2:0] F_PUSH = 3'd5;

  logic [2:0]                       state_r, state_nxt;
  logic signed [31:0]               xs_r, ys_r;
  logic [63:0]                      sq_r, rad_r;
  logic [34:0]                      rem_r;
  logic [31:0]                      root_r;
  logic [4:0]                       cnt_r;
  logic                             pass_r;
  logic signed [35:0]               vx_r, vy_r;
  logic signed [sah_pkg::ANG_W-1:0] vz_r, tilt_r, dir_r;

  logic                             accept;
  logic signed [31:0]               mul_op;
  logic signed [63:0]               prod;
  logic [34:0]                      rem_sh, test;
  logic                             ge;
  logic [34:0]                      rem_nxt;
  logic [31:0]                      root_nxt;
  logic signed [35:0]               sh_x, sh_y, vx_nxt, vy_nxt;
  logic signed [sah_pkg::ANG_W-1:0] vz_nxt, ang, vz_wrap;
  logic                             zero_slope;

  assign in_ch.ready = (state_r == F_IDLE) && !q_full && !bk_stat.clearing;
  assign accept      = in_ch.valid && in_ch.ready;
  assign zero_slope  = (xs_r == '0) && (ys_r == '0);

  always_comb begin
    mul_op = (state_r == F_SQX) ? xs_r : ys_r;
    prod   = mul_op * mul_op;

    rem_sh = {rem_r[32:0], rad_r[63:62]};
    test   = {1'b0, root_r, 2'b01};
    ge     = rem_sh >= test;
    rem_nxt  = ge ? rem_sh - test : rem_sh;
    root_nxt = {root_r[30:0], ge};

    sh_x = vx_r >>> cnt_r;
    sh_y = vy_r >>> cnt_r;
    ang  = sah_pkg::atan_q24(cnt_r);
    if (vy_r >= 0) begin
      vx_nxt = vx_r + sh_y;
      vy_nxt = vy_r - sh_x;
      vz_nxt = vz_r + ang;
    end else begin
      vx_nxt = vx_r - sh_y;
      vy_nxt = vy_r + sh_x;
      vz_nxt = vz_r - ang;
    end
    vz_wrap = sah_pkg::wrap_q24(vz_nxt);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (accept && in_ch.operation == sah_pkg::OP_ACC) state_nxt = F_SQX;
      F_SQX:  state_nxt = F_SQY;
      F_SQY:  state_nxt = F_SQRT;
      F_SQRT: if (cnt_r == 5'd31) state_nxt = F_VEC;
      F_VEC: begin
        if (cnt_r == 5'(sah_pkg::CORDIC_STEPS - 1) && (pass_r || zero_slope))
          state_nxt = F_PUSH;
      end
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        xs_r <= in_ch.x_slope;
        ys_r <= in_ch.y_slope;
      end
      F_SQX: sq_r <= $unsigned(prod);
      F_SQY: begin
        rad_r  <= sq_r + $unsigned(prod);
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end
      F_SQRT: begin
        rad_r  <= {rad_r[61:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          vx_r   <= 36'sd65536;
          vy_r   <= $signed({4'b0, root_nxt});
          vz_r   <= '0;
          pass_r <= 1'b0;
          cnt_r  <= '0;
        end
      end
      F_VEC: begin
        vx_r  <= vx_nxt;
        vy_r  <= vy_nxt;
        vz_r  <= vz_nxt;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(sah_pkg::CORDIC_STEPS - 1)) begin
          cnt_r <= '0;
          if (pass_r) begin
            dir_r <= vz_wrap;
          end else begin
            tilt_r <= vz_wrap;
            pass_r <= 1'b1;
            if (zero_slope) begin
              dir_r <= '0;
            end else if (xs_r < 0) begin
              vx_r <= -(36'(xs_r));
              vy_r <= -(36'(ys_r));
              vz_r <= (ys_r >= 0) ? sah_pkg::Q24_PI : -sah_pkg::Q24_PI;
            end else begin
              vx_r <= 36'(xs_r);
              vy_r <= 36'(ys_r);
              vz_r <= '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    q_wr.push = (state_r == F_PUSH && !q_full) ||
                (accept && (in_ch.operation == sah_pkg::OP_READ ||
                            in_ch.operation == sah_pkg::OP_RDCLR));
    q_wr.cmd.op        = (state_r == F_IDLE) ? in_ch.operation : sah_pkg::OP_ACC;
    q_wr.cmd.tilt      = tilt_r;
    q_wr.cmd.dir       = dir_r;
    q_wr.cmd.bin_index = in_ch.bin_index;
  end

endmodule

// ===== rtl/core/sah_queue.sv =====
module sah_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  sah_pkg::q_wr_t q_wr,
  output logic           q_full,
  input  logic           q_pop,
  output sah_pkg::q_rd_t q_rd
);

  sah_pkg::cmd_t                slot_r [sah_pkg::Q_DEPTH];
  logic [sah_pkg::Q_AW-1:0]     wp_r, rp_r;
  logic [sah_pkg::Q_AW:0]       cnt_r;

  assign q_full     = cnt_r == (sah_pkg::Q_AW + 1)'(sah_pkg::Q_DEPTH);
  assign q_rd.valid = cnt_r != '0;
  assign q_rd.cmd   = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (q_wr.push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      if (q_wr.push && !q_pop) cnt_r <= cnt_r + 1'b1;
      else if (!q_wr.push && q_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) slot_r[wp_r] <= q_wr.cmd;
  end

endmodule

// ===== rtl/core/sah_back.sv =====
module sah_back (
  input  logic              clk,
  input  logic              rst_n,
  input  sah_pkg::cfg_t     cfg,
  input  sah_pkg::q_rd_t    q_rd,
  output logic              q_pop,
  sah_out_if.source         out_ch,
  output sah_pkg::bk_stat_t bk_stat
);

  localparam int AW = sah_pkg::ANG_W;
  localparam int RW = sah_pkg::ROT_W;
  localparam int CW = sah_pkg::COUNT_WIDTH;
  localparam int BW = sah_pkg::BIN_AW;
  localparam int GW = sah_pkg::COORD_W;

  localparam logic signed [AW:0] PI_W     = (AW+1)'(sah_pkg::Q24_PI);
  localparam logic signed [AW:0] TWO_PI_W = (AW+1)'(sah_pkg::Q24_TWO_PI);

  localparam logic [3:0] B_CLR  = 4'd0;
  localparam logic [3:0] B_IDLE = 4'd1;
  localparam logic [3:0] B_LOAD = 4'd2;
  localparam logic [3:0] B_ROT  = 4'd3;
  localparam logic [3:0] B_M1   = 4'd4;
  localparam logic [3:0] B_M2   = 4'd5;
  localparam logic [3:0] B_M3   = 4'd6;
  localparam logic [3:0] B_M4   = 4'd7;
  localparam logic [3:0] B_ADDR = 4'd8;
  localparam logic [3:0] B_RD   = 4'd9;
  localparam logic [3:0] B_WR   = 4'd10;
  localparam logic [3:0] B_RDA  = 4'd11;
  localparam logic [3:0] B_RDD  = 4'd12;

  logic [CW-1:0] hist_mem [sah_pkg::BIN_DEPTH];

  logic [3:0]           state_r, state_nxt;
  logic [BW-1:0]        clr_r, addr_r;
  logic [1:0]           op_r;
  logic signed [AW-1:0] tilt_r, dir_r, res_r;
  logic [9:0]           j_r;
  logic [4:0]           cnt_r;
  logic signed [RW-1:0] x1_r, y1_r, x2_r, y2_r;
  logic signed [AW-1:0] z1_r, z2_r;
  logic                 neg1_r, neg2_r;
  logic signed [61:0]   prod_v_r;
  logic signed [65:0]   prod_c_r, prod_s_r, tc_r, ts_r;
  logic [GW-1:0]        row_r, col_r;
  logic [CW-1:0]        rd_data_r, out_data_r;
  logic                 out_valid_r;

  logic [8:0]           g, gm1;
  logic [9:0]           n;
  logic signed [AW-1:0] theta, a1, a2, f1, f2, ang, res_sum;
  logic signed [AW:0]   a_diff;
  logic [AW:0]          res_wide;
  logic                 fn1, fn2;
  logic signed [RW-1:0] x1_nxt, y1_nxt, x2_nxt, y2_nxt, cd, ct, st;
  logic signed [AW-1:0] z1_nxt, z2_nxt;
  logic signed [31:0]   v, uc, us;
  logic signed [65:0]   scale_s, g_off;
  logic signed [25:0]   tcs, tss;
  logic [GW-1:0]        col_c, row_c;
  logic [16:0]          addr_c;
  logic                 out_load, mem_we;
  logic [BW-1:0]        mem_wa;
  logic [CW-1:0]        mem_wd, sat_inc;

  always_comb begin
    if (cfg.grid_size == '0) g = 9'd1;
    else if (cfg.grid_size > 9'(sah_pkg::MAX_GRID)) g = 9'(sah_pkg::MAX_GRID);
    else g = cfg.grid_size;
    gm1 = g - 9'd1;
    n = (cfg.step_count > 10'(sah_pkg::MAX_STEPS)) ? 10'(sah_pkg::MAX_STEPS) : cfg.step_count;

    theta = (res_r >= sah_pkg::Q24_PI) ? res_r - sah_pkg::Q24_TWO_PI : res_r;
    a_diff = (AW+1)'(theta) - (AW+1)'(dir_r);
    if (a_diff >= PI_W) a_diff = a_diff - TWO_PI_W;
    if (a_diff < -PI_W) a_diff = a_diff + TWO_PI_W;
    a1 = a_diff[AW-1:0];
    a2 = theta;
    fn1 = 1'b0;
    f1  = a1;
    if (a1 > sah_pkg::Q24_HALF_PI) begin
      f1 = a1 - sah_pkg::Q24_PI;
      fn1 = 1'b1;
    end else if (a1 < -sah_pkg::Q24_HALF_PI) begin
      f1 = a1 + sah_pkg::Q24_PI;
      fn1 = 1'b1;
    end
    fn2 = 1'b0;
    f2  = a2;
    if (a2 > sah_pkg::Q24_HALF_PI) begin
      f2 = a2 - sah_pkg::Q24_PI;
      fn2 = 1'b1;
    end else if (a2 < -sah_pkg::Q24_HALF_PI) begin
      f2 = a2 + sah_pkg::Q24_PI;
      fn2 = 1'b1;
    end

    ang = sah_pkg::atan_q24(cnt_r);
    if (z1_r >= 0) begin
      x1_nxt = x1_r - (y1_r >>> cnt_r);
      y1_nxt = y1_r + (x1_r >>> cnt_r);
      z1_nxt = z1_r - ang;
    end else begin
      x1_nxt = x1_r + (y1_r >>> cnt_r);
      y1_nxt = y1_r - (x1_r >>> cnt_r);
      z1_nxt = z1_r + ang;
    end
    if (z2_r >= 0) begin
      x2_nxt = x2_r - (y2_r >>> cnt_r);
      y2_nxt = y2_r + (x2_r >>> cnt_r);
      z2_nxt = z2_r - ang;
    end else begin
      x2_nxt = x2_r + (y2_r >>> cnt_r);
      y2_nxt = y2_r - (x2_r >>> cnt_r);
      z2_nxt = z2_r + ang;
    end

    cd = neg1_r ? -x1_r : x1_r;
    ct = neg2_r ? -x2_r : x2_r;
    st = neg2_r ? -y2_r : y2_r;
    v  = prod_v_r[61:30];
    uc = prod_c_r[61:30];
    us = prod_s_r[61:30];
    scale_s = $signed({34'b0, cfg.bin_scale});
    g_off   = $signed({18'b0, g, 39'b0});

    tcs = tc_r[65:40];
    tss = ts_r[65:40];
    if (tcs < 0) col_c = '0;
    else if (tcs > $signed({17'b0, gm1})) col_c = gm1[GW-1:0];
    else col_c = tcs[GW-1:0];
    if (tss < 0) row_c = '0;
    else if (tss > $signed({17'b0, gm1})) row_c = gm1[GW-1:0];
    else row_c = tss[GW-1:0];

    addr_c = row_r * g + {9'b0, col_r};

    res_wide = {1'b0, res_r} + {4'b0, cfg.angle_step};
    if (res_wide >= $unsigned(TWO_PI_W)) res_wide = res_wide - $unsigned(TWO_PI_W);
    res_sum = $signed(res_wide[AW-1:0]);

    sat_inc  = (rd_data_r == '1) ? rd_data_r : rd_data_r + 1'b1;
    out_load = (state_r == B_RDD) && (!out_valid_r || out_ch.ready);

    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = '0;
    if (state_r == B_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_r;
    end else if (state_r == B_WR) begin
      mem_we = 1'b1;
      mem_wd = sat_inc;
    end else if (out_load && op_r == sah_pkg::OP_RDCLR) begin
      mem_we = 1'b1;
    end
  end

  assign q_pop            = (state_r == B_IDLE) && q_rd.valid;
  assign bk_stat.clearing = state_r == B_CLR;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.bin_count = out_data_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_CLR:  if (clr_r == '1) state_nxt = B_IDLE;
      B_IDLE: begin
        if (q_rd.valid) begin
          if (q_rd.cmd.op != sah_pkg::OP_ACC) state_nxt = B_RDA;
          else if (n != '0) state_nxt = B_LOAD;
        end
      end
      B_LOAD: state_nxt = B_ROT;
      B_ROT:  if (cnt_r == 5'(sah_pkg::CORDIC_STEPS - 1)) state_nxt = B_M1;
      B_M1:   state_nxt = B_M2;
      B_M2:   state_nxt = B_M3;
      B_M3:   state_nxt = B_M4;
      B_M4:   state_nxt = B_ADDR;
      B_ADDR: state_nxt = B_RD;
      B_RD:   state_nxt = B_WR;
      B_WR:   state_nxt = (j_r == n - 10'd1) ? B_IDLE : B_LOAD;
      B_RDA:  state_nxt = B_RDD;
      B_RDD:  if (out_load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLR) clr_r <= clr_r + 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[mem_wa] <= mem_wd;
    rd_data_r <= hist_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= rd_data_r;
    case (state_r)
      B_IDLE: begin
        op_r   <= q_rd.cmd.op;
        tilt_r <= q_rd.cmd.tilt;
        dir_r  <= q_rd.cmd.dir;
        addr_r <= q_rd.cmd.bin_index;
        j_r    <= '0;
        res_r  <= '0;
      end
      B_LOAD: begin
        x1_r   <= sah_pkg::Q30_INV_GAIN;
        y1_r   <= '0;
        z1_r   <= f1;
        neg1_r <= fn1;
        x2_r   <= sah_pkg::Q30_INV_GAIN;
        y2_r   <= '0;
        z2_r   <= f2;
        neg2_r <= fn2;
        cnt_r  <= '0;
      end
      B_ROT: begin
        x1_r  <= x1_nxt;
        y1_r  <= y1_nxt;
        z1_r  <= z1_nxt;
        x2_r  <= x2_nxt;
        y2_r  <= y2_nxt;
        z2_r  <= z2_nxt;
        cnt_r <= cnt_r + 5'd1;
      end
      B_M1: prod_v_r <= tilt_r * cd;
      B_M2: begin
        prod_c_r <= v * ct;
        prod_s_r <= v * st;
      end
      B_M3: begin
        tc_r <= 66'(uc) * scale_s + g_off;
        ts_r <= 66'(us) * scale_s + g_off;
      end
      B_M4: begin
        col_r <= col_c;
        row_r <= row_c;
      end
      B_ADDR: addr_r <= addr_c[BW-1:0];
      B_WR: begin
        j_r   <= j_r + 10'd1;
        res_r <= res_sum;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/slope_angle_histogram.sv =====
// channel   direction  handshake            payload
// in_ch     in         valid/ready          operation, x_slope, y_slope, bin_index
// out_ch    out        valid/ready          bin_count
// apb       in         psel/penable/pready  paddr, pwdata, prdata
//
// Accumulate: the front runs an isqrt and two CORDIC vectorings (one for a zero
// slope), then the back runs step_count steps (at most 512); each step runs two 24-step CORDIC
// rotations, a multiply chain and a read-modify-write of the bin memory.
// Read and read-clear skip the front's arithmetic. A 4-entry queue separates front and back.
// After reset a clearing pass zeroes all 65536 bins; no transaction is taken on in_ch
// meanwhile. Reset is synchronous, active low.
module slope_angle_histogram (
  input  logic        clk,
  input  logic        rst_n,
  sah_in_if.sink      in_ch,
  sah_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sah_pkg::cfg_t     cfg_r;
  sah_pkg::q_wr_t    q_wr;
  sah_pkg::q_rd_t    q_rd;
  sah_pkg::bk_stat_t bk_stat;
  logic              q_full, q_pop;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_size  <= 9'd200;
      cfg_r.step_count <= 10'd360;
      cfg_r.angle_step <= 25'd292818;
      cfg_r.bin_scale  <= '0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        sah_pkg::REG_GRID:  cfg_r.grid_size  <= pwdata[8:0];
        sah_pkg::REG_STEPS: cfg_r.step_count <= pwdata[9:0];
        sah_pkg::REG_ANGLE: cfg_r.angle_step <= pwdata[24:0];
        sah_pkg::REG_SCALE: cfg_r.bin_scale  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      sah_pkg::REG_GRID:  prdata = {23'b0, cfg_r.grid_size};
      sah_pkg::REG_STEPS: prdata = {22'b0, cfg_r.step_count};
      sah_pkg::REG_ANGLE: prdata = {7'b0, cfg_r.angle_step};
      sah_pkg::REG_SCALE: prdata = cfg_r.bin_scale;
      default:            prdata = '0;
    endcase
  end

  sah_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .bk_stat (bk_stat),
    .q_wr    (q_wr)
  );

  sah_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_rd   (q_rd)
  );

  sah_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_rd    (q_rd),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .bk_stat (bk_stat)
  );

`ifndef SYNTHESIS
  a_no_in_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !bk_stat.clearing)
    else $error("transaction accepted during clearing pass");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> (!q_full || q_pop))
    else $error("queue push while full");

  a_reset_starts_clear: assert property (@(posedge clk)
    !rst_n |=> bk_stat.clearing)
    else $error("clearing pass not started after reset");
`endif

endmodule

// ===== dv/slope_angle_histogram_test.sv =====
`timescale 1ns / 100ps
module slope_angle_histogram_test;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam longint ARC_PI = 52707179;
  localparam longint ARC_TWO_PI = 105414358;
  localparam longint ARC_HALF_PI = 26353589;
  localparam longint UNIT_GAIN = 652032874;
  localparam longint ARC_TAB [sah_pkg::CORDIC_STEPS] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sah_in_if  in_ch ();
  sah_out_if out_ch ();

  slope_angle_histogram dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bit [31:0]   bin_counts [sah_pkg::BIN_DEPTH];
  bit [8:0]    grid_reg = 9'd200;
  bit [9:0]    steps_reg = 10'd360;
  bit [24:0]   angle_reg = 25'd292818;
  bit [31:0]   scale_reg = 32'd0;
  bit [31:0]   counts_due [$];
  int unsigned touched_bins [$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = sah_pkg::OP_READ;
    in_ch.x_slope = '0;
    in_ch.y_slope = '0;
    in_ch.bin_index = '0;
    out_ch.ready = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic longint fold_arc(input longint a);
    longint r;
    r = a % ARC_TWO_PI;
    if (r >= ARC_PI) r -= ARC_TWO_PI;
    if (r < -ARC_PI) r += ARC_TWO_PI;
    return r;
  endfunction

  function automatic longint heading(input longint x, input longint y);
    longint z, nx;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? ARC_PI : -ARC_PI;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < sah_pkg::CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ARC_TAB[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ARC_TAB[i];
      end
      x = nx;
    end
    return fold_arc(z);
  endfunction

  function automatic void rotate_unit(input longint a, output longint c, output longint s);
    longint x, y, nx;
    bit flip;
    x = UNIT_GAIN;
    y = 0;
    flip = 1'b0;
    a = fold_arc(a);
    if (a > ARC_HALF_PI) begin
      a -= ARC_PI;
      flip = 1'b1;
    end else if (a < -ARC_HALF_PI) begin
      a += ARC_PI;
      flip = 1'b1;
    end
    for (int i = 0; i < sah_pkg::CORDIC_STEPS; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        a -= ARC_TAB[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        a += ARC_TAB[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned root, bitpos;
    root = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > n) bitpos >>= 2;
    while (bitpos != 0) begin
      if (n >= root + bitpos) begin
        n -= root + bitpos;
        root = (root >> 1) + bitpos;
      end else begin
        root >>= 1;
      end
      bitpos >>= 2;
    end
    return root;
  endfunction

  function automatic longint grid_coord(input longint u, input longint g);
    longint t;
    t = (u * longint'(scale_reg) + (g <<< 39)) >>> 40;
    if (t < 0) return 0;
    if (t > g - 1) return g - 1;
    return t;
  endfunction

  function automatic void add_slope(input logic signed [31:0] xs, input logic signed [31:0] ys);
    longint x, y, mag, tilt, dir, g, n, theta, cd, sd, ct, st, v, row, col;
    longint unsigned sq;
    int unsigned addr;
    x = xs;
    y = ys;
    sq = longint'(x * x) + longint'(y * y);
    mag = longint'(root64(sq));
    tilt = heading(65536, mag);
    dir = (x == 0 && y == 0) ? 0 : heading(x, y);
    g = (grid_reg < 1) ? 1 :
        ((grid_reg > sah_pkg::MAX_GRID) ? sah_pkg::MAX_GRID : grid_reg);
    n = (steps_reg > sah_pkg::MAX_STEPS) ? sah_pkg::MAX_STEPS : steps_reg;
    for (longint j = 0; j < n; j++) begin
      theta = fold_arc(j * longint'(angle_reg));
      rotate_unit(theta - dir, cd, sd);
      rotate_unit(theta, ct, st);
      v = (tilt * cd) >>> 30;
      col = grid_coord((v * ct) >>> 30, g);
      row = grid_coord((v * st) >>> 30, g);
      addr = row * g + col;
      if (addr < sah_pkg::BIN_DEPTH) begin
        if (bin_counts[addr] != 32'hFFFF_FFFF) bin_counts[addr]++;
        touched_bins.push_back(addr);
        if (touched_bins.size() > 64) void'(touched_bins.pop_front());
      end
    end
  endfunction

  function automatic void apply_item(input logic [1:0] op, input logic signed [31:0] xs,
                                     input logic signed [31:0] ys, input logic [15:0] idx);
    case (op)
      sah_pkg::OP_ACC: add_slope(xs, ys);
      sah_pkg::OP_READ: counts_due.push_back(bin_counts[idx]);
      sah_pkg::OP_RDCLR: begin
        counts_due.push_back(bin_counts[idx]);
        bin_counts[idx] = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] op, input logic signed [31:0] xs,
                           input logic signed [31:0] ys, input logic [15:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.x_slope <= xs;
    in_ch.y_slope <= ys;
    in_ch.bin_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_item(op, xs, ys, idx);
  endtask

  // a read queues behind every earlier slope, so its result marks the block idle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (counts_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic settle();
    send_item(sah_pkg::OP_READ, '0, '0, '0);
    drain_results();
  endtask

  task automatic write_reg(input logic [1:0] which, input logic [31:0] value);
    logic [31:0] kept;
    case (which)
      sah_pkg::REG_GRID: kept = value & 32'h1FF;
      sah_pkg::REG_STEPS: kept = value & 32'h3FF;
      sah_pkg::REG_ANGLE: kept = value & 32'h1FF_FFFF;
      default: kept = value;
    endcase
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (which)
      sah_pkg::REG_GRID: grid_reg = kept[8:0];
      sah_pkg::REG_STEPS: steps_reg = kept[9:0];
      sah_pkg::REG_ANGLE: angle_reg = kept[24:0];
      default: scale_reg = kept;
    endcase
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== kept)
      flag_mismatch($sformatf("register %0d reads %h, wrote %h", which, prdata, kept));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_mode(input logic [31:0] g, input logic [31:0] n,
                          input logic [31:0] a, input logic [31:0] s);
    settle();
    write_reg(sah_pkg::REG_GRID, g);
    write_reg(sah_pkg::REG_STEPS, n);
    write_reg(sah_pkg::REG_ANGLE, a);
    write_reg(sah_pkg::REG_SCALE, s);
  endtask

  function automatic logic [31:0] any_slope();
    case ($urandom_range(3))
      0: return 32'(int'($urandom_range(524288)) - 262144);
      1: return $urandom();
      2: return 32'(int'($urandom_range(131072)) - 65536);
      default: return ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [15:0] hit_index();
    if (touched_bins.size() == 0) return 16'($urandom());
    return 16'(touched_bins[$urandom_range(touched_bins.size() - 1)]);
  endfunction

  function automatic logic [1:0] any_read();
    return $urandom_range(1) ? sah_pkg::OP_READ : sah_pkg::OP_RDCLR;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (counts_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected bin_count %h", out_ch.bin_count));
      end else if (out_ch.bin_count !== counts_due[0]) begin
        flag_mismatch($sformatf("bin_count %h, want %h", out_ch.bin_count, counts_due[0]));
        void'(counts_due.pop_front());
      end else begin
        void'(counts_due.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic test_defaults();
    settle();
    send_item(sah_pkg::OP_ACC, '0, '0, '0);
    send_item(sah_pkg::OP_READ, '0, '0, 16'd20100);
    send_item(sah_pkg::OP_RDCLR, '0, '0, 16'd20100);
    send_item(sah_pkg::OP_READ, '0, '0, 16'd20100);
    send_item(OP_IGNORED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(sah_pkg::OP_READ, '0, '0, 16'hFFFF);
    send_item(sah_pkg::OP_RDCLR, '0, '0, 16'h0000);
  endtask

  task automatic test_extremes();
    set_mode(256, 6, 32'h1FF_FFFF, 32'hFFFF_FFFF);
    send_item(sah_pkg::OP_ACC, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    send_item(sah_pkg::OP_ACC, 32'h8000_0000, 32'h8000_0000, '0);
    send_item(sah_pkg::OP_ACC, 32'h0000_0001, 32'hFFFF_FFFF, '0);
    send_item(sah_pkg::OP_RDCLR, '0, '0, hit_index());
    send_item(sah_pkg::OP_READ, '0, '0, hit_index());
    set_mode(10, 6, 0, 10 * 20861);
    send_item(sah_pkg::OP_ACC, 32'h0001_8000, 32'hFFFF_0000, '0);
    send_item(sah_pkg::OP_READ, '0, '0, hit_index());
  endtask

  task automatic test_clamps();
    set_mode(0, 6, 17569062, 32'd50000);
    send_item(sah_pkg::OP_ACC, 32'h0000_8000, 32'h0000_4000, '0);
    set_mode(511, 0, 17569062, 256 * 20861);
    send_item(sah_pkg::OP_ACC, 32'h0002_0000, 32'h0001_0000, '0);
    set_mode(64, 1023, 205887, 64 * 20861);
    send_item(sah_pkg::OP_ACC, 32'hFFFE_0000, 32'h0000_C000, '0);
    send_item(sah_pkg::OP_READ, '0, '0, hit_index());
    send_item(sah_pkg::OP_RDCLR, '0, '0, hit_index());
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int items);
    int unsigned g, n, a, pick;
    g = ($urandom_range(3) == 0) ? $urandom_range(10, 256) : $urandom_range(10, 40);
    n = $urandom_range(6, 24);
    a = ($urandom_range(4) == 0) ? $urandom_range(32'h1FF_FFFF) : 105414358 / n;
    set_mode(g, n, a, $urandom_range(g * 10000, g * 42000));
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (items) begin
      pick = $urandom_range(99);
      if (pick < 35) send_item(sah_pkg::OP_ACC, any_slope(), any_slope(), 16'($urandom()));
      else if (pick < 80)
        send_item(any_read(), $urandom(), $urandom(), hit_index());
      else if (pick < 92)
        send_item(any_read(), $urandom(), $urandom(), 16'($urandom()));
      else send_item(OP_IGNORED, $urandom(), $urandom(), 16'($urandom()));
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    send_item(sah_pkg::OP_ACC, 32'h0000_9000, 32'hFFFF_7000, '0);
    hold_cycles = 500;
    repeat (16) send_item(any_read(), '0, '0, hit_index());
    drain_results();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_extremes();
    test_clamps();
    test_random_phase(0, 0, 150);
    test_random_phase(65, 0, 150);
    test_random_phase(0, 65, 150);
    test_random_phase(23, 23, 150);
    test_backpressure();
    drain_results();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== slope_angle_histogram.f =====
rtl/core/sah_pkg.sv
rtl/core/sah_in_if.sv
rtl/core/sah_out_if.sv
rtl/core/sah_front.sv
rtl/core/sah_queue.sv
rtl/core/sah_back.sv
rtl/core/slope_angle_histogram.sv
dv/slope_angle_histogram_test.sv
